### rtl/pctt_pkg.sv
// Package for the periodic CAN transmit table core.
// Holds the command and status codes, the sequencer states and the slot descriptor type.
// No dependencies.
package pctt_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_EDIT   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_NO_ID    = 2'd2,
    STAT_NOTHING  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Identifier that every slot holds until it is first written.
  localparam logic [28:0] RESET_IDENT = 29'h900;

  // Everything stored per slot except the data bytes, the last send time and the slot flags.
  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic        ext;
    logic        rtr;
    logic [31:0] period;
  } desc_t;

  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic        ext;
    logic        rtr;
    logic [63:0] bytes;
  } frame_t;

endpackage

### rtl/periodic_can_tx_table.sv
// Top level of the periodic CAN transmit table.
// Depends on pctt_pkg for codes, states and the slot descriptor type.
//
// Usage: one command channel (in_valid_i / in_stall_o) carries add, remove, edit and
// tick beats; one result channel (out_valid_o / out_stall_i) returns result beats.
// A beat moves at a clock edge where valid is high and stall is low.
// Add, remove and edit give exactly one result beat with last_o set. A tick gives one
// beat per frame that is due, in ascending slot order, with last_o on the final one,
// or a single nothing_to_transmit beat when no frame is due.
// Every command walks the whole table through one compare unit, one slot per cycle
// while the scan is not held, with the slot memories read one slot ahead of the
// compare. A command holds the input stalled from its acceptance through the scan and
// the done state, and its final result beat enters the result register as the done
// state ends, so the next command is taken only once the block is idle again. A due
// frame or the final beat waiting on a full, stalled result register prolongs the stall.
// The result register lets the block move on while its beat waits, so a stalled
// receiver only holds the scan when a due frame finds both the result register
// and the one-frame holding stage occupied. Reset empties the table: all slots free,
// last send times zero, identifiers 0x900; no clearing pass is needed.
module periodic_can_tx_table_core #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [28:0] match_id_i,
  input  logic [28:0] frame_id_i,
  input  logic [3:0]  frame_len_i,
  input  logic        frame_ext_i,
  input  logic        frame_rtr_i,
  input  logic [63:0] frame_bytes_i,
  input  logic [31:0] send_period_i,
  input  logic [63:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        has_frame_o,
  output logic [28:0] out_id_o,
  output logic [3:0]  out_len_o,
  output logic        out_ext_o,
  output logic        out_rtr_o,
  output logic [63:0] out_bytes_o,
  output logic        last_o
);

  localparam int IDXW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDXW:0] SLOTS_C = (IDXW + 1)'(TABLE_SLOTS);

  pctt_pkg::state_e state_q, state_d;

  // Captured command.
  pctt_pkg::kind_e kind_q;
  logic [28:0] match_q, fid_q;
  logic [3:0]  flen_q;
  logic        fext_q, frtr_q;
  logic [63:0] fbytes_q, now_q;
  logic [31:0] per_q;

  // Scan sequencer: fetch counter and the slot under compare.
  logic [IDXW:0]   fc_q, fc_d;
  logic            ev_valid_q, ev_valid_d;
  logic [IDXW-1:0] ev_idx_q, ev_idx_d;
  logic            hit_q, hit_d;
  logic [IDXW-1:0] hit_idx_q, hit_idx_d;

  // Per-slot flags in flip-flops.
  logic [TABLE_SLOTS-1:0] busy_q, busy_d;
  logic [TABLE_SLOTS-1:0] id_ok_q, id_ok_d;
  logic [TABLE_SLOTS-1:0] ls_ok_q, ls_ok_d;

  // Slot memories.
  pctt_pkg::desc_t        desc_mem [TABLE_SLOTS];
  logic [7:0][7:0]        pay_mem  [TABLE_SLOTS];
  logic [63:0]            ls_mem   [TABLE_SLOTS];
  pctt_pkg::desc_t        desc_rd_q;
  logic [7:0][7:0]        pay_rd_q;
  logic [63:0]            ls_rd_q;

  logic            rd_en;
  logic            desc_we;
  logic [7:0]      pay_be;
  logic            ls_we;
  logic [IDXW-1:0] wr_idx;
  pctt_pkg::desc_t desc_wd;

  // Frame held back until it is known whether another one follows it.
  logic              pend_q, pend_d;
  pctt_pkg::frame_t  pend_fr_q, pend_fr_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic             out_has_q, out_has_d;
  pctt_pkg::frame_t out_fr_q, out_fr_d;
  logic             out_last_q, out_last_d;

  // Compare unit.
  logic [28:0]      ev_id;
  logic [63:0]      ev_ls;
  logic [63:0]      elapsed;
  logic             due;
  logic             out_free;
  logic             block;
  pctt_pkg::frame_t ev_fr;

  assign ev_id    = id_ok_q[ev_idx_q] ? desc_rd_q.id : pctt_pkg::RESET_IDENT;
  assign ev_ls    = ls_ok_q[ev_idx_q] ? ls_rd_q : 64'd0;
  assign elapsed  = now_q - ev_ls;
  assign due      = busy_q[ev_idx_q] && (elapsed >= {32'd0, desc_rd_q.period});
  assign out_free = !out_valid_q || !out_stall_i;
  assign block    = ev_valid_q && (kind_q == pctt_pkg::KIND_TICK) && due && pend_q && !out_free;

  assign ev_fr.id    = desc_rd_q.id;
  assign ev_fr.len   = desc_rd_q.len;
  assign ev_fr.ext   = desc_rd_q.ext;
  assign ev_fr.rtr   = desc_rd_q.rtr;
  assign ev_fr.bytes = pay_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pctt_pkg::ST_IDLE;
      fc_q        <= '0;
      ev_valid_q  <= 1'b0;
      hit_q       <= 1'b0;
      busy_q      <= '0;
      id_ok_q     <= '0;
      ls_ok_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      ev_valid_q  <= ev_valid_d;
      hit_q       <= hit_d;
      busy_q      <= busy_d;
      id_ok_q     <= id_ok_d;
      ls_ok_q     <= ls_ok_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pctt_pkg::ST_IDLE && in_valid_i) begin
      kind_q   <= pctt_pkg::kind_e'(kind_i);
      match_q  <= match_id_i;
      fid_q    <= frame_id_i;
      flen_q   <= frame_len_i;
      fext_q   <= frame_ext_i;
      frtr_q   <= frame_rtr_i;
      fbytes_q <= frame_bytes_i;
      per_q    <= send_period_i;
      now_q    <= now_time_i;
    end
    ev_idx_q     <= ev_idx_d;
    hit_idx_q    <= hit_idx_d;
    pend_fr_q    <= pend_fr_d;
    out_status_q <= out_status_d;
    out_has_q    <= out_has_d;
    out_fr_q     <= out_fr_d;
    out_last_q   <= out_last_d;
  end

  // Slot memories, read one slot ahead of the compare.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      desc_rd_q <= desc_mem[fc_q[IDXW-1:0]];
      pay_rd_q  <= pay_mem[fc_q[IDXW-1:0]];
      ls_rd_q   <= ls_mem[fc_q[IDXW-1:0]];
    end
    if (desc_we) begin
      desc_mem[wr_idx] <= desc_wd;
    end
    for (int b = 0; b < 8; b++) begin
      if (pay_be[b]) begin
        pay_mem[wr_idx][b] <= fbytes_q[8*b +: 8];
      end
    end
    if (ls_we) begin
      ls_mem[ev_idx_q] <= now_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    busy_d       = busy_q;
    id_ok_d      = id_ok_q;
    ls_ok_d      = ls_ok_q;
    pend_d       = pend_q;
    pend_fr_d    = pend_fr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_has_d    = out_has_q;
    out_fr_d     = out_fr_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    desc_we      = 1'b0;
    pay_be       = '0;
    ls_we        = 1'b0;
    wr_idx       = hit_idx_q;
    desc_wd.id     = fid_q;
    desc_wd.len    = flen_q;
    desc_wd.ext    = fext_q;
    desc_wd.rtr    = frtr_q;
    desc_wd.period = per_q;

    case (state_q)
      pctt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          fc_d       = '0;
          ev_valid_d = 1'b0;
          hit_d      = 1'b0;
          pend_d     = 1'b0;
          state_d    = pctt_pkg::ST_SCAN;
        end
      end

      pctt_pkg::ST_SCAN: begin
        if (!block) begin
          // Compare the slot fetched by the last read.
          if (ev_valid_q) begin
            case (kind_q)
              pctt_pkg::KIND_ADD: begin
                if (!busy_q[ev_idx_q] && !hit_q) begin
                  hit_d     = 1'b1;
                  hit_idx_d = ev_idx_q;
                end
              end
              pctt_pkg::KIND_REMOVE, pctt_pkg::KIND_EDIT: begin
                if (ev_id == match_q) begin
                  hit_d     = 1'b1;
                  hit_idx_d = ev_idx_q;
                end
              end
              default: begin
                if (due) begin
                  // A due frame pushes the held one out, which is then not the last.
                  if (pend_q) begin
                    out_valid_d  = 1'b1;
                    out_status_d = pctt_pkg::STAT_OK;
                    out_has_d    = 1'b1;
                    out_fr_d     = pend_fr_q;
                    out_last_d   = 1'b0;
                  end
                  pend_d             = 1'b1;
                  pend_fr_d          = ev_fr;
                  ls_we              = 1'b1;
                  ls_ok_d[ev_idx_q]  = 1'b1;
                end
              end
            endcase
          end
          if (fc_q < SLOTS_C) begin
            rd_en      = 1'b1;
            ev_valid_d = 1'b1;
            ev_idx_d   = fc_q[IDXW-1:0];
            fc_d       = fc_q + 1'b1;
          end else begin
            ev_valid_d = 1'b0;
            state_d    = pctt_pkg::ST_DONE;
          end
        end
      end

      pctt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_has_d    = 1'b0;
          out_fr_d     = '0;
          out_last_d   = 1'b1;
          out_status_d = pctt_pkg::STAT_OK;
          state_d      = pctt_pkg::ST_IDLE;
          case (kind_q)
            pctt_pkg::KIND_ADD: begin
              if (hit_q) begin
                desc_we           = 1'b1;
                pay_be            = '1;
                busy_d[hit_idx_q] = 1'b1;
                id_ok_d[hit_idx_q] = 1'b1;
              end else begin
                out_status_d = pctt_pkg::STAT_NO_SPACE;
              end
            end
            pctt_pkg::KIND_REMOVE: begin
              if (hit_q) begin
                busy_d[hit_idx_q] = 1'b0;
              end else begin
                out_status_d = pctt_pkg::STAT_NO_ID;
              end
            end
            pctt_pkg::KIND_EDIT: begin
              if (hit_q) begin
                desc_we            = 1'b1;
                id_ok_d[hit_idx_q] = 1'b1;
                // Only the first len bytes are rewritten; a length above eight takes all.
                for (int b = 0; b < 8; b++) begin
                  pay_be[b] = (4'(b) < flen_q);
                end
              end else begin
                out_status_d = pctt_pkg::STAT_NO_ID;
              end
            end
            default: begin
              if (pend_q) begin
                out_has_d = 1'b1;
                out_fr_d  = pend_fr_q;
                pend_d    = 1'b0;
              end else begin
                out_status_d = pctt_pkg::STAT_NOTHING;
              end
            end
          endcase
        end
      end

      default: begin
        state_d = pctt_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != pctt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign has_frame_o = out_has_q;
  assign out_id_o    = out_fr_q.id;
  assign out_len_o   = out_fr_q.len;
  assign out_ext_o   = out_fr_q.ext;
  assign out_rtr_o   = out_fr_q.rtr;
  assign out_bytes_o = out_fr_q.bytes;
  assign last_o      = out_last_q;

endmodule
